/* rtl/core/ptc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the pressure/temperature compensation core.
// Depends on nothing; every other file in rtl/core except ptc_fifo imports it.
package ptc_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SENS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TCS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TCO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TREF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPSENS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODEL    = 3'd6;

  localparam int FRONT_STAGES = 5;
  localparam int BACK_STAGES  = 6;
  localparam int FRONT_BUSY_W = $clog2(FRONT_STAGES + 1);
  localparam int BACK_BUSY_W  = $clog2(BACK_STAGES + 1);

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] pressure_value;
  } result_t;

  typedef struct packed {
    logic [15:0] coef_sens;
    logic [15:0] coef_off;
    logic [15:0] coef_tcs;
    logic [15:0] coef_tco;
    logic [15:0] coef_tref;
    logic [15:0] coef_tempsens;
    logic        model_select;
  } cfg_t;

  // Request handed from the front pipeline to the back pipeline.
  typedef struct packed {
    logic [23:0]        raw_pressure;
    logic signed [34:0] sens1;
    logic signed [35:0] offs1;
    logic [31:0]        corr_off;
    logic [31:0]        corr_sens;
    logic signed [31:0] temperature_centi;
    logic               two_bar;
  } work_t;

endpackage

/* rtl/core/ptc_fifo.sv */
`timescale 1ns / 1ps
// Small show-ahead queue in flip-flops, width and depth set by parameters.
// Standalone; callers guarantee no push when full and no pop when empty.
module ptc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr];
  assign empty = (fill == '0);
  assign count = fill;

endmodule

/* rtl/core/ptc_front.sv */
`timescale 1ns / 1ps
// Front pipeline: takes raw samples, forms temperature, first-order offset and
// sensitivity, classifies the temperature band and builds the corrections. Uses ptc_pkg.
module ptc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  ptc_pkg::sample_t                    sample,
  input  ptc_pkg::cfg_t                       cfg,
  output logic                                out_valid,
  output ptc_pkg::work_t                      item,
  output logic [ptc_pkg::FRONT_BUSY_W-1:0]    busy
);
  import ptc_pkg::*;

  localparam logic signed [17:0] TDEV_COLD = -18'sd3600;
  localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [18:0] COLD_REF  = 19'sd3500;

  logic [FRONT_STAGES-1:0] vld;
  logic                    two_bar;

  // stage 1
  logic [23:0]        s1_d1;
  logic signed [24:0] s1_dtemp;
  logic signed [24:0] dtemp_c;
  // stage 2
  logic [23:0]        s2_d1;
  logic signed [41:0] s2_c3dt, s2_c4dt, s2_c6dt;
  logic [47:0]        s2_dsq;
  logic signed [41:0] c3dt_c, c4dt_c, c6dt_c;
  logic signed [49:0] dsq_c;
  // stage 3
  logic [23:0]        s3_d1;
  logic signed [17:0] s3_tdev;
  logic signed [34:0] s3_sens1;
  logic signed [35:0] s3_offs1;
  logic [16:0]        s3_corr_t;
  logic [41:0]        c3b, c4b, c6b;
  logic [34:0]        c3q, sens1_c;
  logic [35:0]        c4q, offs1_c;
  logic [17:0]        tdev_c;
  logic [51:0]        dsq11;
  logic [49:0]        dsq3;
  logic [16:0]        corr_t_c;
  // stage 4
  logic [23:0]        s4_d1;
  logic signed [34:0] s4_sens1;
  logic signed [35:0] s4_offs1;
  logic [33:0]        s4_sqd;
  logic [31:0]        s4_sqc;
  logic [31:0]        s4_tfinal;
  logic               s4_low, s4_cold;
  logic signed [18:0] t1_c, tcold_c;
  logic signed [35:0] sqd_c;
  logic signed [37:0] sqc_c;
  logic [19:0]        tfin_c;
  // stage 5
  logic [38:0]        m31;
  logic [39:0]        m63;
  logic [35:0]        m3, m5;
  logic [31:0]        c7, c4v;
  logic [31:0]        corr_off_c, corr_sens_c;

  assign two_bar = cfg.model_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_STAGES-2:0], accept};
    end
  end

  assign out_valid = vld[FRONT_STAGES-1];
  assign busy      = FRONT_BUSY_W'($countones(vld));

  // stage 1: temperature difference
  assign dtemp_c = $signed({1'b0, sample.raw_temperature})
                 - $signed({1'b0, cfg.coef_tref, 8'h00});

  always_ff @(posedge clk) begin
    s1_d1    <= sample.raw_pressure;
    s1_dtemp <= dtemp_c;
  end

  // stage 2: products with the temperature difference
  assign c3dt_c = $signed({1'b0, cfg.coef_tcs}) * s1_dtemp;
  assign c4dt_c = $signed({1'b0, cfg.coef_tco}) * s1_dtemp;
  assign c6dt_c = $signed({1'b0, cfg.coef_tempsens}) * s1_dtemp;
  assign dsq_c  = s1_dtemp * s1_dtemp;

  always_ff @(posedge clk) begin
    s2_d1   <= s1_d1;
    s2_c3dt <= c3dt_c;
    s2_c4dt <= c4dt_c;
    s2_c6dt <= c6dt_c;
    s2_dsq  <= dsq_c[47:0];
  end

  // stage 3: truncating scales, first-order terms, band and temperature correction
  assign c3b = s2_c3dt + (s2_c3dt[41] ? (two_bar ? 42'd127 : 42'd255) : 42'd0);
  assign c3q = two_bar ? c3b[41:7] : {c3b[41], c3b[41:8]};
  assign sens1_c = (two_bar ? {3'b000, cfg.coef_sens, 16'h0000}
                            : {4'b0000, cfg.coef_sens, 15'h0000}) + c3q;

  assign c4b = s2_c4dt + (s2_c4dt[41] ? (two_bar ? 42'd63 : 42'd127) : 42'd0);
  assign c4q = two_bar ? c4b[41:6] : {c4b[41], c4b[41:7]};
  assign offs1_c = (two_bar ? {3'b000, cfg.coef_off, 17'h00000}
                            : {4'b0000, cfg.coef_off, 16'h0000}) + c4q;

  assign c6b    = s2_c6dt + (s2_c6dt[41] ? 42'd8388607 : 42'd0);
  assign tdev_c = c6b[40:23];

  assign dsq11 = {1'b0, s2_dsq, 3'b000} + {3'b000, s2_dsq, 1'b0} + {4'b0000, s2_dsq};
  assign dsq3  = {1'b0, s2_dsq, 1'b0} + {2'b00, s2_dsq};

  always_comb begin
    unique case ({two_bar, tdev_c[17]})
      2'b11:   corr_t_c = dsq11[51:35];
      2'b10:   corr_t_c = '0;
      2'b01:   corr_t_c = dsq3[49:33];
      default: corr_t_c = {5'b00000, s2_dsq[47:36]};
    endcase
  end

  always_ff @(posedge clk) begin
    s3_d1     <= s2_d1;
    s3_tdev   <= $signed(tdev_c);
    s3_sens1  <= $signed(sens1_c);
    s3_offs1  <= $signed(offs1_c);
    s3_corr_t <= corr_t_c;
  end

  // stage 4: first-pass temperature, squares, final temperature
  assign t1_c    = $signed({s3_tdev[17], s3_tdev}) + TEMP_REF;
  assign tcold_c = $signed({s3_tdev[17], s3_tdev}) + COLD_REF;
  assign sqd_c   = s3_tdev * s3_tdev;
  assign sqc_c   = tcold_c * tcold_c;
  assign tfin_c  = {t1_c[18], t1_c} - {3'b000, s3_corr_t};

  always_ff @(posedge clk) begin
    s4_d1     <= s3_d1;
    s4_sens1  <= s3_sens1;
    s4_offs1  <= s3_offs1;
    s4_sqd    <= sqd_c[33:0];
    s4_sqc    <= sqc_c[31:0];
    s4_tfinal <= {{12{tfin_c[19]}}, tfin_c};
    s4_low    <= s3_tdev[17];
    s4_cold   <= (s3_tdev <= TDEV_COLD);
  end

  // stage 5: offset and sensitivity corrections, wrapped to 32 bits
  assign m31 = {s4_sqd, 5'b00000} - {5'b00000, s4_sqd};
  assign m63 = {s4_sqd, 6'b000000} - {6'b000000, s4_sqd};
  assign m3  = {1'b0, s4_sqd, 1'b0} + {2'b00, s4_sqd};
  assign m5  = {s4_sqd, 2'b00} + {2'b00, s4_sqd};
  assign c7  = {s4_sqc[28:0], 3'b000} - s4_sqc;
  assign c4v = {s4_sqc[29:0], 2'b00};

  always_comb begin
    unique case ({two_bar, s4_low})
      2'b11: begin
        corr_off_c  = m31[34:3];
        corr_sens_c = m63[36:5];
      end
      2'b10: begin
        corr_off_c  = '0;
        corr_sens_c = '0;
      end
      2'b01: begin
        corr_off_c  = m3[32:1] + (s4_cold ? c7 : 32'h0);
        corr_sens_c = m5[34:3] + (s4_cold ? c4v : 32'h0);
      end
      default: begin
        corr_off_c  = {2'b00, s4_sqd[33:4]};
        corr_sens_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item.raw_pressure      <= s4_d1;
    item.sens1             <= s4_sens1;
    item.offs1             <= s4_offs1;
    item.corr_off          <= corr_off_c;
    item.corr_sens         <= corr_sens_c;
    item.temperature_centi <= $signed(s4_tfinal);
    item.two_bar           <= two_bar;
  end

endmodule

/* rtl/core/ptc_back.sv */
`timescale 1ns / 1ps
// Back pipeline: applies the corrections and scales the raw pressure to the
// compensated pressure. Uses ptc_pkg.
module ptc_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  input  ptc_pkg::work_t                     item,
  output logic                               out_valid,
  output ptc_pkg::result_t                   res,
  output logic [ptc_pkg::BACK_BUSY_W-1:0]    busy
);
  import ptc_pkg::*;

  logic [BACK_STAGES-1:0] vld;

  logic [23:0]        b1_d1;
  logic [35:0]        b1_sens2;
  logic [36:0]        b1_offs2, b2_offs2, b3_offs2, b4_offs2;
  logic [31:0]        b1_temp, b2_temp, b3_temp, b4_temp, b5_temp;
  logic               b1_two, b2_two, b3_two, b4_two, b5_two;
  logic [41:0]        b2_pl;
  logic signed [42:0] b2_ph;
  logic [59:0]        b3_p;
  logic [38:0]        b4_q;
  logic [39:0]        b5_r;

  logic [59:0]        pb;
  logic [39:0]        rb;
  logic [31:0]        pres_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[BACK_STAGES-2:0], take};
    end
  end

  assign out_valid = vld[BACK_STAGES-1];
  assign busy      = BACK_BUSY_W'($countones(vld));

  // stage 1: corrected sensitivity and offset
  always_ff @(posedge clk) begin
    b1_d1    <= item.raw_pressure;
    b1_sens2 <= {item.sens1[34], item.sens1} - {{4{item.corr_sens[31]}}, item.corr_sens};
    b1_offs2 <= {item.offs1[35], item.offs1} - {{5{item.corr_off[31]}}, item.corr_off};
    b1_temp  <= item.temperature_centi;
    b1_two   <= item.two_bar;
  end

  // stage 2: partial products of raw pressure and sensitivity
  always_ff @(posedge clk) begin
    b2_pl    <= b1_d1 * b1_sens2[17:0];
    b2_ph    <= $signed({1'b0, b1_d1}) * $signed(b1_sens2[35:18]);
    b2_offs2 <= b1_offs2;
    b2_temp  <= b1_temp;
    b2_two   <= b1_two;
  end

  // stage 3: combine partial products
  always_ff @(posedge clk) begin
    b3_p     <= {b2_ph[41:0], 18'h00000} + {18'h00000, b2_pl};
    b3_offs2 <= b2_offs2;
    b3_temp  <= b2_temp;
    b3_two   <= b2_two;
  end

  // stage 4: truncating divide by 2^21
  assign pb = b3_p + (b3_p[59] ? 60'd2097151 : 60'd0);

  always_ff @(posedge clk) begin
    b4_q     <= pb[59:21];
    b4_offs2 <= b3_offs2;
    b4_temp  <= b3_temp;
    b4_two   <= b3_two;
  end

  // stage 5: remove offset
  always_ff @(posedge clk) begin
    b5_r    <= {b4_q[38], b4_q} - {{3{b4_offs2[36]}}, b4_offs2};
    b5_temp <= b4_temp;
    b5_two  <= b4_two;
  end

  // stage 6: truncating divide by the model scale
  assign rb = b5_r + (b5_r[39] ? (b5_two ? 40'd32767 : 40'd8191) : 40'd0);
  assign pres_c = b5_two ? {{7{rb[39]}}, rb[39:15]} : {{5{rb[39]}}, rb[39:13]};

  always_ff @(posedge clk) begin
    res.temperature_centi <= $signed(b5_temp);
    res.pressure_value    <= $signed(pres_c);
  end

endmodule

/* rtl/core/pressure_temperature_compensation_core.sv */
`timescale 1ns / 1ps
// Second-order temperature compensation of a pressure sensor: each request of raw
// pressure D1 and raw temperature D2 gives one result of temperature in 0.01 degC
// and compensated pressure, using calibration words C1..C6 and the model select
// written through the register port. The core takes one request per clock while full is
// low and returns results in order; each request passes through the 5 front stages, the
// middle queue, the 6 back stages and the output queue before its result is on the
// result ports. Request intake is limited by credit on the middle queue, and the
// back by credit on the output queue, so each depth should be at least its pipeline
// length plus two to sustain one request per clock. Write registers only while the
// core is empty.
module pressure_temperature_compensation_core #(
  parameter int MID_DEPTH = 8,
  parameter int OUT_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  ptc_pkg::sample_t                  sample,
  output logic                              empty,
  input  logic                              pop,
  output ptc_pkg::result_t                  result,
  input  logic                              cfg_write,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptc_pkg::CFG_W-1:0]         cfg_data
);
  import ptc_pkg::*;

  localparam int MID_CW = $clog2(MID_DEPTH + 1);
  localparam int OUT_CW = $clog2(OUT_DEPTH + 1);
  localparam int MID_SW = $clog2(MID_DEPTH + FRONT_STAGES + 1);
  localparam int OUT_SW = $clog2(OUT_DEPTH + BACK_STAGES + 1);

  cfg_t                    cfg;
  logic                    accept;
  logic                    front_valid;
  work_t                   front_item;
  logic [FRONT_BUSY_W-1:0] front_busy;
  work_t                   mid_item;
  logic                    mid_empty;
  logic [MID_CW-1:0]       mid_count;
  logic                    back_take;
  logic                    back_valid;
  result_t                 back_res;
  logic [BACK_BUSY_W-1:0]  back_busy;
  logic [OUT_CW-1:0]       out_count;
  logic                    out_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SENS:     cfg.coef_sens     <= cfg_data;
        REG_OFF:      cfg.coef_off      <= cfg_data;
        REG_TCS:      cfg.coef_tcs      <= cfg_data;
        REG_TCO:      cfg.coef_tco      <= cfg_data;
        REG_TREF:     cfg.coef_tref     <= cfg_data;
        REG_TEMPSENS: cfg.coef_tempsens <= cfg_data;
        REG_MODEL:    cfg.model_select  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign full   = (MID_SW'(mid_count) + MID_SW'(front_busy)) >= MID_SW'(MID_DEPTH);
  assign accept = push && !full;

  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample    (sample),
    .cfg       (cfg),
    .out_valid (front_valid),
    .item      (front_item),
    .busy      (front_busy)
  );

  ptc_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_item),
    .pop   (back_take),
    .rdata (mid_item),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign back_take = !mid_empty
                  && ((OUT_SW'(out_count) + OUT_SW'(back_busy)) < OUT_SW'(OUT_DEPTH));

  ptc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .take      (back_take),
    .item      (mid_item),
    .out_valid (back_valid),
    .res       (back_res),
    .busy      (back_busy)
  );

  assign out_pop = pop && !empty;

  ptc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid),
    .wdata (back_res),
    .pop   (out_pop),
    .rdata (result),
    .empty (empty),
    .count (out_count)
  );

endmodule
